[rtl/ilrb_pkg.sv]
// Shared constants for the roll balancer: window geometry, fixed-point widths,
// phase codes and configuration register indexes.
// No dependencies.
package ilrb_pkg;

    // Averaging window
    localparam int WINDOW   = 10;
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PRIME_W  = $clog2(WINDOW + 1);

    // Sample and running sum widths
    localparam int SAMPLE_W = 17;
    localparam int SUM_W    = $clog2(WINDOW) + SAMPLE_W;
    // magnitude of the sum in whole degrees (sum / 256)
    localparam int A_W      = SUM_W - 8;

    // Reciprocal of WINDOW for the mean: q0 = (a * RECIP) >> RECIP_SH
    localparam int RECIP_SH = 24;
    localparam int RECIP_W  = RECIP_SH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / WINDOW);

    // Arithmetic widths
    localparam int MEAN_W   = 9;
    localparam int W_W      = 32;
    localparam int P1_W     = 26;   // rate * mean
    localparam int DM_W     = 10;   // mean - reflex
    localparam int D_W      = 36;   // weight increment
    localparam int EXTRA_W  = 42;   // weight * mean + reflex, Q.20

    // Thresholds in whole degrees and the drive cap in percent
    localparam logic [MEAN_W-1:0] STOP_LIMIT   = MEAN_W'(50);
    localparam logic [MEAN_W-1:0] REFLEX_LIMIT = MEAN_W'(3);
    localparam logic [6:0]        SPEED_MAX    = 7'd100;

    // Round phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PRIME = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RIGHT = 3'd4;

endpackage

[rtl/ilrb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ilrb_ram #(
    parameter  int WIDTH = 17,
    parameter  int DEPTH = 10,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ico_learning_roll_balancer_top.sv]
// Roll balancer top level: sample window in RAM, running mean, ICO learning
// step and motor command generation. Uses ilrb_pkg and ilrb_ram.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready    | start_req, roll_sample
//  out     | out       | out_valid / out_ready  | speeds, dirs, mean_angle, weights, finished
//
// Steps per word: a start word or an ignored word is taken in idle alone; a priming
// sample adds the sum update and write-back (its oldest slot counts as zero).
// A running sample passes sum, two mean steps, drive and output; a learning step adds
// two chained multiplies and the weight update, and a stop command skips drive.
// Reset clears control state and configuration; the window RAM needs no clear,
// as a start forces the priming pass to overwrite every slot before it is read.
// The output register frees the input side: the next word is accepted while a
// result waits; only the final load stalls until the output register is free.
module ico_learning_roll_balancer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ilrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data,
    // input words
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                start_req,
    input  logic signed [ilrb_pkg::SAMPLE_W-1:0] roll_sample,
    // output words
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [6:0]                          speed_left,
    output logic                                dir_left,
    output logic [6:0]                          speed_right,
    output logic                                dir_right,
    output logic signed [8:0]                   mean_angle,
    output logic signed [31:0]                  weight_left_out,
    output logic signed [31:0]                  weight_right_out,
    output logic                                finished
);

    localparam int SLOT_W   = ilrb_pkg::SLOT_W;
    localparam int PRIME_W  = ilrb_pkg::PRIME_W;
    localparam int SAMPLE_W = ilrb_pkg::SAMPLE_W;
    localparam int SUM_W    = ilrb_pkg::SUM_W;
    localparam int A_W      = ilrb_pkg::A_W;
    localparam int RSH      = ilrb_pkg::RECIP_SH;
    localparam int RECIP_W  = ilrb_pkg::RECIP_W;
    localparam int MEAN_W   = ilrb_pkg::MEAN_W;
    localparam int W_W      = ilrb_pkg::W_W;
    localparam int P1_W     = ilrb_pkg::P1_W;
    localparam int DM_W     = ilrb_pkg::DM_W;
    localparam int D_W      = ilrb_pkg::D_W;
    localparam int EXTRA_W  = ilrb_pkg::EXTRA_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_MEAN1 = 4'd2;
    localparam logic [3:0] S_MEAN2 = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_DRIVE = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // Speed from a Q.20 drive term: base plus whole part of |extra|, capped
    function automatic logic [6:0] drive_speed(input logic signed [EXTRA_W-1:0] extra,
                                               input logic [6:0] base);
        logic [EXTRA_W-1:0]    mag_full;
        logic [EXTRA_W-21:0]   mag;
        logic [7:0]            s;
        mag_full = extra[EXTRA_W-1] ? EXTRA_W'(-extra) : EXTRA_W'(extra);
        mag      = mag_full[EXTRA_W-1:20];
        s        = {1'b0, base} + {1'b0, mag[6:0]};
        if ((mag >= (EXTRA_W-20)'(ilrb_pkg::SPEED_MAX)) || (s >= {1'b0, ilrb_pkg::SPEED_MAX}))
        begin
            return ilrb_pkg::SPEED_MAX;
        end
        return s[6:0];
    endfunction

    // ---------------------------------------------------------------- state
    logic [3:0]                 state_reg,  state_next;
    logic [1:0]                 phase_reg,  phase_next;
    logic [SLOT_W-1:0]          slot_reg,   slot_next;
    logic [PRIME_W-1:0]         prime_reg,  prime_next;
    logic signed [SUM_W-1:0]    sum_reg,    sum_next;
    logic signed [MEAN_W-1:0]   reflex_reg, reflex_next;
    logic signed [W_W-1:0]      wl_reg,     wl_next;
    logic signed [W_W-1:0]      wr_reg,     wr_next;

    // configuration
    logic [15:0]                rate_reg;
    logic [6:0]                 base_l_reg;
    logic [6:0]                 base_r_reg;
    logic signed [W_W-1:0]      init_wl_reg;
    logic signed [W_W-1:0]      init_wr_reg;

    // datapath
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [A_W-1:0]             a_reg;
    logic [A_W-1:0]             q0_reg;
    logic                       neg_reg;
    logic signed [MEAN_W-1:0]   m_reg;
    logic                       stop_reg;
    logic signed [P1_W-1:0]     p1_reg;
    logic signed [DM_W-1:0]     dm_reg;
    logic signed [D_W-1:0]      d_reg;
    logic signed [EXTRA_W-1:0]  extra_l_reg;
    logic signed [EXTRA_W-1:0]  extra_r_reg;

    // output word
    logic                       out_valid_reg;
    logic [6:0]                 speed_l_reg;
    logic [6:0]                 speed_r_reg;
    logic                       dir_l_reg;
    logic                       dir_r_reg;
    logic signed [MEAN_W-1:0]   mean_out_reg;
    logic signed [W_W-1:0]      wl_out_reg;
    logic signed [W_W-1:0]      wr_out_reg;
    logic                       fin_out_reg;

    logic                       ram_we;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic                       out_load;

    // mean arithmetic
    logic [SUM_W-1:0]           sum_abs;
    logic [A_W+RECIP_W-1:0]     recip_prod;
    logic [A_W-1:0]             q0w;
    logic [A_W-1:0]             rem;
    logic [A_W-1:0]             q_fix;
    logic [MEAN_W-1:0]          q_mag;
    logic [MEAN_W:0]            m_wide;

    // learning and drive arithmetic
    logic signed [W_W-1:0]      w_sel;
    logic signed [W_W+4:0]      w_sum;
    logic signed [W_W-1:0]      w_sat;
    logic signed [W_W+MEAN_W-1:0] prod_l;
    logic signed [W_W+MEAN_W-1:0] prod_r;
    logic signed [EXTRA_W-1:0]  reflex_q20;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    // ---------------------------------------------------------- window RAM
    ilrb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (ilrb_pkg::WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (x_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // slots are unwritten since the start while priming: they count as zero
    assign old_sample = (phase_reg == ilrb_pkg::PH_PRIME) ? '0 : $signed(ram_rdata);

    // ---------------------------------------------------------- mean path
    assign sum_abs    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign recip_prod = sum_abs[SUM_W-1:8] * ilrb_pkg::RECIP;
    assign q0w        = A_W'(q0_reg * ilrb_pkg::WINDOW);
    assign rem        = a_reg - q0w;
    assign q_fix      = (rem >= A_W'(ilrb_pkg::WINDOW)) ? q0_reg + 1'b1 : q0_reg;
    assign q_mag      = q_fix[MEAN_W-1:0];
    assign m_wide     = neg_reg ? -{1'b0, q_mag} : {1'b0, q_mag};

    // ---------------------------------------------------------- weight update
    assign w_sel = m_reg[MEAN_W-1] ? wr_reg : wl_reg;
    assign w_sum = {{5{w_sel[W_W-1]}}, w_sel} + {d_reg[D_W-1], d_reg};

    always_comb
    begin
        if (w_sum > (W_W+5)'(signed'(32'sh7FFF_FFFF)))
        begin
            w_sat = 32'sh7FFF_FFFF;
        end
        else if (w_sum < (W_W+5)'(signed'(32'sh8000_0000)))
        begin
            w_sat = 32'sh8000_0000;
        end
        else
        begin
            w_sat = w_sum[W_W-1:0];
        end
    end

    // ---------------------------------------------------------- drive terms
    assign prod_l     = wl_reg * m_reg;
    assign prod_r     = wr_reg * m_reg;
    assign reflex_q20 = {{(EXTRA_W-MEAN_W-20){reflex_reg[MEAN_W-1]}}, reflex_reg, 20'd0};

    // ---------------------------------------------------------- sequencer
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        slot_next   = slot_reg;
        prime_next  = prime_reg;
        sum_next    = sum_reg;
        reflex_next = reflex_reg;
        wl_next     = wl_reg;
        wr_next     = wr_reg;
        ram_we      = 1'b0;
        out_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (start_req)
                    begin
                        sum_next    = '0;
                        slot_next   = '0;
                        prime_next  = '0;
                        reflex_next = '0;
                        wl_next     = init_wl_reg;
                        wr_next     = init_wr_reg;
                        phase_next  = ilrb_pkg::PH_PRIME;
                    end
                    else if ((phase_reg == ilrb_pkg::PH_PRIME) ||
                             (phase_reg == ilrb_pkg::PH_RUN))
                    begin
                        state_next = S_SUM;
                    end
                end
            end

            // replace the oldest sample and update the running sum
            S_SUM:
            begin
                ram_we   = 1'b1;
                sum_next = sum_reg
                         + {{(SUM_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg}
                         - {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
                slot_next = (slot_reg == SLOT_W'(ilrb_pkg::WINDOW - 1)) ? '0
                                                                         : slot_reg + 1'b1;
                if (phase_reg == ilrb_pkg::PH_PRIME)
                begin
                    prime_next = prime_reg + 1'b1;
                    if (prime_reg == PRIME_W'(ilrb_pkg::WINDOW - 1))
                    begin
                        phase_next = ilrb_pkg::PH_RUN;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_MEAN1;
                end
            end

            S_MEAN1:
            begin
                state_next = S_MEAN2;
            end

            // mean is final here: stop, learn, or zero the reflex
            S_MEAN2:
            begin
                if (q_mag > ilrb_pkg::STOP_LIMIT)
                begin
                    state_next = S_OUT;
                end
                else if (q_mag > ilrb_pkg::REFLEX_LIMIT)
                begin
                    state_next = S_MUL1;
                end
                else
                begin
                    reflex_next = '0;
                    state_next  = S_DRIVE;
                end
            end

            S_MUL1:
            begin
                state_next = S_MUL2;
            end

            S_MUL2:
            begin
                state_next = S_UPD;
            end

            // positive mean trains the left weight, negative the right
            S_UPD:
            begin
                if (m_reg[MEAN_W-1])
                begin
                    wr_next = w_sat;
                end
                else
                begin
                    wl_next = w_sat;
                end
                reflex_next = m_reg;
                state_next  = S_DRIVE;
            end

            S_DRIVE:
            begin
                state_next = S_OUT;
            end

            // load the output word once the previous one has gone
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (stop_reg)
                    begin
                        phase_next = ilrb_pkg::PH_DONE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= ilrb_pkg::PH_IDLE;
            slot_reg   <= '0;
            prime_reg  <= '0;
            sum_reg    <= '0;
            reflex_reg <= '0;
            wl_reg     <= '0;
            wr_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            slot_reg   <= slot_next;
            prime_reg  <= prime_next;
            sum_reg    <= sum_next;
            reflex_reg <= reflex_next;
            wl_reg     <= wl_next;
            wr_reg     <= wr_next;
        end
    end

    // ---------------------------------------------------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg    <= '0;
            base_l_reg  <= '0;
            base_r_reg  <= '0;
            init_wl_reg <= '0;
            init_wr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ilrb_pkg::CFG_RATE:       rate_reg    <= cfg_data[15:0];
                ilrb_pkg::CFG_BASE_LEFT:  base_l_reg  <= cfg_data[6:0];
                ilrb_pkg::CFG_BASE_RIGHT: base_r_reg  <= cfg_data[6:0];
                ilrb_pkg::CFG_INIT_LEFT:  init_wl_reg <= cfg_data;
                ilrb_pkg::CFG_INIT_RIGHT: init_wr_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ---------------------------------------------------------- datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            x_reg <= roll_sample;
        end

        // truncating mean: |sum| / 256 by shift, / WINDOW by reciprocal
        if (state_reg == S_MEAN1)
        begin
            a_reg   <= sum_abs[SUM_W-1:8];
            q0_reg  <= recip_prod[A_W+RSH-1:RSH];
            neg_reg <= sum_reg[SUM_W-1];
        end

        if (state_reg == S_MEAN2)
        begin
            m_reg    <= m_wide[MEAN_W-1:0];
            stop_reg <= (q_mag > ilrb_pkg::STOP_LIMIT);
        end

        // rate * m, then * (m - reflex)
        if (state_reg == S_MUL1)
        begin
            p1_reg <= $signed({1'b0, rate_reg}) * m_reg;
            dm_reg <= {m_reg[MEAN_W-1], m_reg} - {reflex_reg[MEAN_W-1], reflex_reg};
        end

        if (state_reg == S_MUL2)
        begin
            d_reg <= p1_reg * dm_reg;
        end

        if (state_reg == S_DRIVE)
        begin
            extra_l_reg <= {prod_l[W_W+MEAN_W-1], prod_l} + reflex_q20;
            extra_r_reg <= {prod_r[W_W+MEAN_W-1], prod_r} + reflex_q20;
        end

        if (out_load)
        begin
            speed_l_reg  <= stop_reg ? 7'd0 : drive_speed(extra_l_reg, base_l_reg);
            speed_r_reg  <= stop_reg ? 7'd0 : drive_speed(extra_r_reg, base_r_reg);
            dir_l_reg    <= stop_reg | ~extra_l_reg[EXTRA_W-1];
            dir_r_reg    <= stop_reg | ~extra_r_reg[EXTRA_W-1];
            mean_out_reg <= m_reg;
            wl_out_reg   <= wl_reg;
            wr_out_reg   <= wr_reg;
            fin_out_reg  <= stop_reg;
        end
    end

    // ---------------------------------------------------------- output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign speed_left       = speed_l_reg;
    assign speed_right      = speed_r_reg;
    assign dir_left         = dir_l_reg;
    assign dir_right        = dir_r_reg;
    assign mean_angle       = mean_out_reg;
    assign weight_left_out  = wl_out_reg;
    assign weight_right_out = wr_out_reg;
    assign finished         = fin_out_reg;

    // ---------------------------------------------------------- assertions
    // write pointer stays inside the window
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(ilrb_pkg::WINDOW - 1))
        else $error("window slot out of range");

    // priming never runs past the window length
    a_prime_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ilrb_pkg::PH_PRIME) |-> (prime_reg < PRIME_W'(ilrb_pkg::WINDOW)))
        else $error("prime count past window");

    // a start word never enters the datapath
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && start_req) |=> (state_reg == S_IDLE))
        else $error("start word entered datapath");

    // a stop command carries zero speeds and forward directions
    a_stop_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |->
            (speed_left == 7'd0 && speed_right == 7'd0 && dir_left && dir_right))
        else $error("malformed stop word");

    // an output word is only loaded into a free register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

endmodule
